// ===== rtl/dmwc_pkg.sv =====
// Package for the direct-mapped write-back cache core.
// Holds the operation, result kind and controller state codes and sizing constants.
// No dependencies.
`timescale 1ns / 1ps
package dmwc_pkg;

  localparam int LINES_DEF = 1024;
  localparam int ADDR_W    = 32;
  localparam int DATA_W    = 64;
  localparam int SETI_W    = 12;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_STORE   = 3'd1,
    OP_FILL    = 3'd2,
    OP_WB_LINE = 3'd3,
    OP_INV     = 3'd4,
    OP_WB_INV  = 3'd5,
    OP_WB_IDX  = 3'd6,
    OP_INV_ALL = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    K_LOAD   = 3'd0,
    K_STORE  = 3'd1,
    K_WBEAT  = 3'd2,
    K_RDREQ  = 3'd3,
    K_MAINT  = 3'd4,
    K_REJECT = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOKUP,
    S_FILL_RD,
    S_ACC,
    S_WB_REQ,
    S_WB_OUT,
    S_DONE
  } state_t;

endpackage

// ===== rtl/dmwc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dmwc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/direct_mapped_writeback_cache_core.sv =====
// Top level of the direct-mapped write-back cache core with 32-byte lines.
// Depends on dmwc_pkg and dmwc_ram (tag and data memories).
`timescale 1ns / 1ps
// One beat is handled at a time. A hit load or store goes through the accept step with
// its tag and data read, the lookup, and the access with the read-modify-write of the
// data word; its result is registered at the end of the access. A rejected beat goes
// straight to the done state; a maintenance op without write-back reaches it after the
// lookup. Each write beat of a dirty victim passes a read request state and an output
// state, because the data memory is read one 8-byte quarter at a time through its single
// read port. A miss ends with a bus read request; the block then accepts fill beats, one
// per cycle, and the fourth completes the pending access through a data read state and
// the access state, where its result is registered. Tag, valid and dirty bits of all
// slots share one memory: after reset, and for every invalidate-all op, a clearing pass
// sweeps it, during which no beat is accepted. Configuration writes are always taken.
module direct_mapped_writeback_cache_core
  import dmwc_pkg::*;
#(
  parameter int LINES = LINES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic [ADDR_W-1:0] in_addr,
  input  logic [1:0]        in_size_code,
  input  logic [DATA_W-1:0] in_wdata,
  input  logic [SETI_W-1:0] in_set_index,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [ADDR_W-1:0] out_bus_addr,
  output logic [DATA_W-1:0] out_rdata,
  output logic [1:0]        out_beat,
  output logic              out_last,
  input  logic              cfg_we,
  input  logic              cfg_wdata
);

  localparam int IDX_W  = $clog2(LINES);
  localparam int TAG_W  = ADDR_W - 5 - IDX_W;
  localparam int TENT_W = TAG_W + 2;
  localparam int WORD_W = IDX_W + 2;

  // Byte mask for the requested access size.
  function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] sc);
    logic [DATA_W-1:0] m;
    unique case (sc)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = '1;
    endcase
    return m;
  endfunction

  state_t state_r, state_nxt;

  logic wbe_r;

  // Pending miss.
  logic              pend_r;
  logic [1:0]        fill_cnt_r;
  op_t               pend_op_r;
  logic [ADDR_W-1:0] pend_addr_r;
  logic [1:0]        pend_sc_r;
  logic [DATA_W-1:0] pend_wd_r;

  // Access being worked on.
  op_t               acc_op_r;
  logic [ADDR_W-1:0] acc_addr_r;
  logic [1:0]        acc_sc_r;
  logic [DATA_W-1:0] acc_wd_r;
  logic [IDX_W-1:0]  slot_r;

  // Decisions made at lookup.
  logic              wb_need;
  logic [TAG_W-1:0]  victim_tag_r;
  logic [1:0]        wb_cnt_r;
  kind_t             done_kind_r;
  logic [ADDR_W-1:0] done_addr_r;
  logic              tagw_en_r;
  logic [TENT_W-1:0] tagw_val_r;
  logic              clr_maint_r;
  logic [IDX_W-1:0]  clr_idx_r;

  // Output register.
  logic              out_valid_r;
  kind_t             out_kind_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [DATA_W-1:0] out_rdata_r;
  logic [1:0]        out_beat_r;
  logic              out_last_r;

  // Memory ports.
  logic              tag_we, tag_re;
  logic [IDX_W-1:0]  tag_waddr, tag_raddr;
  logic [TENT_W-1:0] tag_wdata, tag_rdata;
  logic              data_we, data_re;
  logic [WORD_W-1:0] data_waddr, data_raddr;
  logic [DATA_W-1:0] data_wdata, data_rdata;

  // Output load request.
  logic              out_load;
  kind_t             ld_kind;
  logic [ADDR_W-1:0] ld_addr;
  logic [DATA_W-1:0] ld_rdata;
  logic [1:0]        ld_beat;
  logic              ld_last;

  logic out_free;
  assign out_free = !out_valid_r || out_ready;

  op_t in_op_e;
  assign in_op_e = op_t'(in_op);

  logic in_fire;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  logic [IDX_W-1:0] in_slot, pend_slot;
  logic [TAG_W-1:0] pend_tag, acc_tag;
  assign in_slot   = (in_op_e == OP_WB_IDX) ? in_set_index[IDX_W-1:0] : in_addr[IDX_W+4:5];
  assign pend_slot = pend_addr_r[IDX_W+4:5];
  assign pend_tag  = pend_addr_r[ADDR_W-1:IDX_W+5];
  assign acc_tag   = acc_addr_r[ADDR_W-1:IDX_W+5];

  // An access whose address is not a multiple of its size is refused.
  logic misaligned;
  always_comb begin
    unique case (in_size_code)
      2'd0:    misaligned = 1'b0;
      2'd1:    misaligned = in_addr[0];
      2'd2:    misaligned = |in_addr[1:0];
      default: misaligned = |in_addr[2:0];
    endcase
  end

  logic is_access;
  assign is_access = (in_op_e == OP_LOAD) || (in_op_e == OP_STORE);

  // While a miss is pending only fill beats are taken; a fill beat without a miss
  // is stray.
  logic reject;
  assign reject = pend_r ? (in_op_e != OP_FILL)
                         : ((in_op_e == OP_FILL) || (is_access && misaligned));

  logic fill_fire;
  assign fill_fire = in_fire && pend_r && (in_op_e == OP_FILL);

  // Lookup of the entry read in the accept cycle.
  logic             t_valid, t_dirty, hit;
  logic [TAG_W-1:0] t_tag;
  assign t_valid = tag_rdata[TENT_W-1];
  assign t_dirty = tag_rdata[TENT_W-2];
  assign t_tag   = tag_rdata[TAG_W-1:0];
  assign hit     = t_valid && (t_tag == acc_tag);

  always_comb begin
    unique case (acc_op_r)
      OP_LOAD, OP_STORE: wb_need = !hit && t_valid && t_dirty && wbe_r;
      OP_WB_LINE, OP_WB_INV: wb_need = hit && t_dirty && wbe_r;
      OP_WB_IDX: wb_need = t_valid && t_dirty && wbe_r;
      default: wb_need = 1'b0;
    endcase
  end

  // Byte lane alignment for loads and stores.
  logic [5:0]        acc_sh;
  logic [DATA_W-1:0] acc_mask, load_val, store_word;
  assign acc_sh     = {acc_addr_r[2:0], 3'b000};
  assign acc_mask   = size_mask(acc_sc_r);
  assign load_val   = (data_rdata >> acc_sh) & acc_mask;
  assign store_word = (data_rdata & ~(acc_mask << acc_sh)) | ((acc_wd_r & acc_mask) << acc_sh);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (clr_idx_r == IDX_W'(LINES - 1)) begin
          state_nxt = clr_maint_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          if (reject) begin
            state_nxt = S_DONE;
          end else if (in_op_e == OP_FILL) begin
            if (fill_cnt_r == 2'd3) begin
              state_nxt = S_FILL_RD;
            end
          end else begin
            state_nxt = S_LOOKUP;
          end
        end
      end
      S_LOOKUP: begin
        if (acc_op_r == OP_INV_ALL) begin
          state_nxt = S_CLEAR;
        end else if ((acc_op_r == OP_LOAD || acc_op_r == OP_STORE) && hit) begin
          state_nxt = S_ACC;
        end else if (wb_need) begin
          state_nxt = S_WB_REQ;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_FILL_RD: state_nxt = S_ACC;
      S_ACC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_WB_REQ: state_nxt = S_WB_OUT;
      S_WB_OUT: begin
        if (out_free) begin
          state_nxt = (wb_cnt_r == 2'd3) ? S_DONE : S_WB_REQ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory and output controls.
  always_comb begin
    tag_we     = 1'b0;
    tag_waddr  = slot_r;
    tag_wdata  = '0;
    tag_re     = 1'b0;
    tag_raddr  = in_slot;
    data_we    = 1'b0;
    data_waddr = {slot_r, acc_addr_r[4:3]};
    data_wdata = store_word;
    data_re    = 1'b0;
    data_raddr = {in_slot, in_addr[4:3]};
    out_load   = 1'b0;
    ld_kind    = done_kind_r;
    ld_addr    = '0;
    ld_rdata   = '0;
    ld_beat    = 2'd0;
    ld_last    = 1'b1;
    unique case (state_r)
      S_CLEAR: begin
        tag_we    = 1'b1;
        tag_waddr = clr_idx_r;
      end
      S_IDLE: begin
        if (fill_fire) begin
          data_we    = 1'b1;
          data_waddr = {pend_slot, fill_cnt_r};
          data_wdata = in_wdata;
          if (fill_cnt_r == 2'd3) begin
            tag_we    = 1'b1;
            tag_waddr = pend_slot;
            tag_wdata = {1'b1, 1'b0, pend_tag};
          end
        end else if (in_fire && !reject) begin
          tag_re  = 1'b1;
          data_re = 1'b1;
        end
      end
      S_FILL_RD: begin
        data_re    = 1'b1;
        data_raddr = {slot_r, acc_addr_r[4:3]};
      end
      S_ACC: begin
        if (out_free) begin
          out_load = 1'b1;
          if (acc_op_r == OP_STORE) begin
            ld_kind   = K_STORE;
            data_we   = 1'b1;
            tag_we    = 1'b1;
            tag_wdata = {1'b1, 1'b1, acc_tag};
          end else begin
            ld_kind  = K_LOAD;
            ld_rdata = load_val;
          end
        end
      end
      S_WB_REQ: begin
        data_re    = 1'b1;
        data_raddr = {slot_r, wb_cnt_r};
      end
      S_WB_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          ld_kind  = K_WBEAT;
          ld_addr  = {victim_tag_r, slot_r, 5'b00000};
          ld_rdata = data_rdata;
          ld_beat  = wb_cnt_r;
          ld_last  = 1'b0;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          ld_addr   = done_addr_r;
          tag_we    = tagw_en_r;
          tag_wdata = tagw_val_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      wbe_r       <= 1'b1;
      pend_r      <= 1'b0;
      fill_cnt_r  <= 2'd0;
      wb_cnt_r    <= 2'd0;
      clr_maint_r <= 1'b0;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        wbe_r <= cfg_wdata;
      end
      if (state_r == S_CLEAR) begin
        if (clr_idx_r == IDX_W'(LINES - 1)) begin
          clr_idx_r <= '0;
        end else begin
          clr_idx_r <= clr_idx_r + 1'b1;
        end
      end
      if (fill_fire) begin
        fill_cnt_r <= fill_cnt_r + 1'b1;
        if (fill_cnt_r == 2'd3) begin
          pend_r <= 1'b0;
        end
      end
      if (state_r == S_LOOKUP) begin
        if (acc_op_r == OP_INV_ALL) begin
          clr_maint_r <= 1'b1;
        end else if ((acc_op_r == OP_LOAD || acc_op_r == OP_STORE) && !hit) begin
          pend_r     <= 1'b1;
          fill_cnt_r <= 2'd0;
        end
      end
      if (state_r == S_DONE) begin
        clr_maint_r <= 1'b0;
      end
      if (state_r == S_WB_OUT && out_free) begin
        wb_cnt_r <= wb_cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (in_op_e == OP_FILL) begin
        acc_op_r   <= pend_op_r;
        acc_addr_r <= pend_addr_r;
        acc_sc_r   <= pend_sc_r;
        acc_wd_r   <= pend_wd_r;
        slot_r     <= pend_slot;
      end else begin
        acc_op_r   <= in_op_e;
        acc_addr_r <= in_addr;
        acc_sc_r   <= in_size_code;
        acc_wd_r   <= in_wdata;
        slot_r     <= in_slot;
      end
      done_kind_r <= K_REJECT;
      done_addr_r <= '0;
      tagw_en_r   <= 1'b0;
    end
    if (state_r == S_LOOKUP) begin
      victim_tag_r <= t_tag;
      done_kind_r  <= K_MAINT;
      done_addr_r  <= '0;
      tagw_en_r    <= 1'b0;
      tagw_val_r   <= '0;
      unique case (acc_op_r)
        OP_LOAD, OP_STORE: begin
          // A miss drops the slot until the fill completes.
          done_kind_r <= K_RDREQ;
          done_addr_r <= {acc_addr_r[ADDR_W-1:5], 5'b00000};
          tagw_en_r   <= 1'b1;
          pend_op_r   <= acc_op_r;
          pend_addr_r <= acc_addr_r;
          pend_sc_r   <= acc_sc_r;
          pend_wd_r   <= acc_wd_r;
        end
        OP_WB_LINE, OP_WB_IDX: begin
          tagw_en_r  <= wb_need;
          tagw_val_r <= {1'b1, 1'b0, t_tag};
        end
        OP_INV, OP_WB_INV: tagw_en_r <= hit;
        default: begin
        end
      endcase
    end
    if (out_load) begin
      out_kind_r  <= ld_kind;
      out_addr_r  <= ld_addr;
      out_rdata_r <= ld_rdata;
      out_beat_r  <= ld_beat;
      out_last_r  <= ld_last;
    end
  end

  dmwc_ram #(
    .WIDTH(TENT_W),
    .DEPTH(LINES)
  ) u_tag_ram (
    .clk  (clk),
    .we   (tag_we),
    .waddr(tag_waddr),
    .wdata(tag_wdata),
    .re   (tag_re),
    .raddr(tag_raddr),
    .rdata(tag_rdata)
  );

  dmwc_ram #(
    .WIDTH(DATA_W),
    .DEPTH(4 * LINES)
  ) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(data_wdata),
    .re   (data_re),
    .raddr(data_raddr),
    .rdata(data_rdata)
  );

  assign out_valid    = out_valid_r;
  assign out_kind     = out_kind_r;
  assign out_bus_addr = out_addr_r;
  assign out_rdata    = out_rdata_r;
  assign out_beat     = out_beat_r;
  assign out_last     = out_last_r;

`ifndef SYNTH
  // A beat other than a fill while a miss is pending must end in a refusal.
  a_busy_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && pend_r && in_op_e != OP_FILL) |=>
      (state_r == S_DONE && done_kind_r == K_REJECT))
    else $error("busy beat not rejected");

  // A partial fill count exists only under a pending miss.
  a_fill_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_cnt_r != 2'd0) |-> pend_r)
    else $error("fill count without pending miss");

  // The access stage never runs while a miss is still outstanding.
  a_acc_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> !pend_r)
    else $error("access while miss pending");

  // Write beats carry last low, every other result carries it high.
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (ld_last == (ld_kind != K_WBEAT)))
    else $error("wrong last flag");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for direct_mapped_writeback_cache_core.
// Depends on dmwc_pkg and the cache RTL; directed table first, then random traffic,
// with every result beat checked against a behavioral cache predictor.
`timescale 1ns / 1ps
module tb;
  import dmwc_pkg::*;

  localparam int NSLOT     = 1024;
  localparam int N_RANDOM  = 400;
  localparam int DOG_LIMIT = 8000;
  localparam int LONG_HOLD = 300;

  typedef struct {
    op_t         op;
    logic [31:0] addr;
    logic [1:0]  sc;
    logic [63:0] wd;
    logic [11:0] si;
  } req_t;

  typedef struct {
    kind_t       kind;
    logic [31:0] bus_addr;
    logic [63:0] rdata;
    logic [1:0]  beat;
    logic        last;
  } resp_t;

  // A directed row: the request and, where it is obvious, the single result it gives.
  typedef struct {
    req_t  rq;
    bit    typed;
    kind_t tkind;
  } row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_op = '0;
  logic [ADDR_W-1:0] in_addr = '0;
  logic [1:0]        in_size_code = '0;
  logic [DATA_W-1:0] in_wdata = '0;
  logic [SETI_W-1:0] in_set_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_kind;
  logic [ADDR_W-1:0] out_bus_addr;
  logic [DATA_W-1:0] out_rdata;
  logic [1:0]        out_beat;
  logic              out_last;
  logic              cfg_we = 1'b0;
  logic              cfg_wdata = 1'b0;

  always #10 clk = ~clk;

  direct_mapped_writeback_cache_core #(.LINES(NSLOT)) dut (.*);

  // Predictor state: a shadow copy of the cache arrays and the miss bookkeeping.
  logic [16:0] sh_tag [NSLOT];
  bit          sh_valid [NSLOT];
  bit          sh_dirty [NSLOT];
  logic [63:0] sh_data [NSLOT*4];
  bit          sh_wbe;
  bit          miss_open;
  req_t        miss_req;
  logic [1:0]  fills_seen;

  resp_t awaited_beats[$];
  int    n_errors = 0;
  int    n_items = 0;
  int    n_results = 0;
  int    n_hits = 0;
  int    n_wbeats = 0;
  bit    quiet = 1'b0;
  bit    hold_long = 1'b0;

  task automatic emit(input bit rec, input kind_t k, input logic [31:0] ba,
                      input logic [63:0] rd, input logic [1:0] bt, inout int n);
    resp_t r;
    r.kind = k;
    r.bus_addr = ba;
    r.rdata = rd;
    r.beat = bt;
    r.last = 1'b0;
    if (rec) awaited_beats.push_back(r);
    n++;
  endtask

  task automatic evict_beats(input bit rec, input int s, inout int n);
    logic [31:0] base;
    base = {sh_tag[s], s[9:0], 5'd0};
    for (int b = 0; b < 4; b++) begin
      emit(rec, K_WBEAT, base, sh_data[s*4+b], b[1:0], n);
    end
    sh_dirty[s] = 1'b0;
    n_wbeats += 4;
  endtask

  // Load or store on a slot that is known to hold the line.
  task automatic hit_access(input bit rec, input req_t rq, inout int n);
    int          s, w;
    logic [63:0] m;
    int          sh;
    s = int'(rq.addr[14:5]);
    w = s*4 + int'(rq.addr[4:3]);
    sh = 8 * int'(rq.addr[2:0]);
    m = (rq.sc == 2'd3) ? '1 : ((64'd1 << (8 << rq.sc)) - 64'd1);
    if (rq.op == OP_LOAD) begin
      emit(rec, K_LOAD, '0, (sh_data[w] >> sh) & m, '0, n);
    end else begin
      sh_data[w] = (sh_data[w] & ~(m << sh)) | ((rq.wd & m) << sh);
      sh_dirty[s] = 1'b1;
      emit(rec, K_STORE, '0, '0, '0, n);
    end
  endtask

  // Works out the result beats that one accepted request causes and updates the shadow state.
  task automatic cache_predict(input req_t rq, input bit rec);
    int s, n;
    bit hit;
    n = 0;
    s = int'(rq.addr[14:5]);
    hit = sh_valid[s] && sh_tag[s] == rq.addr[31:15];
    if (rq.op == OP_FILL) begin
      if (!miss_open) begin
        emit(rec, K_REJECT, '0, '0, '0, n);
      end else begin
        s = int'(miss_req.addr[14:5]);
        sh_data[s*4 + int'(fills_seen)] = rq.wd;
        fills_seen++;
        if (fills_seen == 2'd0) begin
          miss_open = 1'b0;
          sh_tag[s] = miss_req.addr[31:15];
          sh_valid[s] = 1'b1;
          sh_dirty[s] = 1'b0;
          hit_access(rec, miss_req, n);
        end
      end
    end else if (miss_open) begin
      emit(rec, K_REJECT, '0, '0, '0, n);
    end else begin
      case (rq.op)
        OP_LOAD, OP_STORE: begin
          if ((rq.addr & ((32'd1 << rq.sc) - 32'd1)) != 0) begin
            emit(rec, K_REJECT, '0, '0, '0, n);
          end else if (hit) begin
            n_hits++;
            hit_access(rec, rq, n);
          end else begin
            if (sh_valid[s] && sh_dirty[s] && sh_wbe) evict_beats(rec, s, n);
            sh_valid[s] = 1'b0;
            sh_dirty[s] = 1'b0;
            miss_open = 1'b1;
            fills_seen = '0;
            miss_req = rq;
            emit(rec, K_RDREQ, {rq.addr[31:5], 5'd0}, '0, '0, n);
          end
        end
        default: begin
          case (rq.op)
            OP_WB_LINE: if (hit && sh_dirty[s] && sh_wbe) evict_beats(rec, s, n);
            OP_INV: if (hit) begin
              sh_valid[s] = 1'b0;
              sh_dirty[s] = 1'b0;
            end
            OP_WB_INV: if (hit) begin
              if (sh_dirty[s] && sh_wbe) evict_beats(rec, s, n);
              sh_valid[s] = 1'b0;
              sh_dirty[s] = 1'b0;
            end
            OP_WB_IDX: begin
              s = int'(rq.si[9:0]);
              if (sh_valid[s] && sh_dirty[s] && sh_wbe) evict_beats(rec, s, n);
            end
            default: begin
              for (int i = 0; i < NSLOT; i++) begin
                sh_valid[i] = 1'b0;
                sh_dirty[i] = 1'b0;
              end
            end
          endcase
          emit(rec, K_MAINT, '0, '0, '0, n);
        end
      endcase
    end
    if (rec && n > 0) awaited_beats[$].last = 1'b1;
  endtask

  // Offers one beat and holds it until the block takes it. The valid stays high on return.
  task automatic offer(input req_t rq, input bit typed, input kind_t tk);
    resp_t r;
    in_valid <= 1'b1;
    in_op <= rq.op;
    in_addr <= rq.addr;
    in_size_code <= rq.sc;
    in_wdata <= rq.wd;
    in_set_index <= rq.si;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    cache_predict(rq, !typed);
    if (typed) begin
      r.kind = tk;
      r.bus_addr = '0;
      r.rdata = '0;
      r.beat = '0;
      r.last = 1'b1;
      awaited_beats.push_back(r);
    end
    n_items++;
  endtask

  // Drops valid and waits until every awaited result has come out, then lets the
  // pipeline settle.
  task automatic drain_sender();
    in_valid <= 1'b0;
    while (awaited_beats.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_write_back(input bit v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sh_wbe = v;
  endtask

  // Random addresses crowd a few slots and tags so that hits, conflicts and dirty
  // evictions happen often.
  function automatic logic [31:0] pick_addr(input logic [1:0] sc);
    logic [16:0] tg;
    logic [9:0]  sl;
    logic [4:0]  off;
    case ($urandom_range(0, 4))
      0: tg = 17'h1FFFF;
      1: tg = 17'($urandom);
      default: tg = 17'($urandom_range(0, 2));
    endcase
    case ($urandom_range(0, 5))
      0: sl = 10'h3FF;
      1: sl = 10'($urandom);
      default: sl = 10'($urandom_range(0, 3));
    endcase
    off = 5'($urandom);
    if ($urandom_range(0, 9) != 0) off = off & ~((5'd1 << sc) - 5'd1);
    return {tg, sl, off};
  endfunction

  function automatic req_t pick_req();
    req_t rq;
    int   p;
    rq.sc = 2'($urandom);
    rq.wd = {$urandom, $urandom};
    rq.si = 12'($urandom);
    if ($urandom_range(0, 1)) rq.si[9:0] = 10'($urandom_range(0, 3));
    rq.addr = pick_addr(rq.sc);
    p = $urandom_range(0, 99);
    if (miss_open && p < 88) rq.op = OP_FILL;
    else if (p < 36) rq.op = OP_LOAD;
    else if (p < 72) rq.op = OP_STORE;
    else if (p < 80) rq.op = OP_WB_LINE;
    else if (p < 86) rq.op = OP_INV;
    else if (p < 92) rq.op = OP_WB_INV;
    else if (p < 97) rq.op = OP_WB_IDX;
    else if (p < 98) rq.op = OP_INV_ALL;
    else rq.op = OP_FILL;
    return rq;
  endfunction

  function automatic row_t mk(input op_t op, input logic [31:0] a, input logic [1:0] sc,
                              input logic [63:0] wd, input bit typed, input kind_t tk);
    row_t r;
    r.rq.op = op;
    r.rq.addr = a;
    r.rq.sc = sc;
    r.rq.wd = wd;
    r.rq.si = '0;
    r.typed = typed;
    r.tkind = tk;
    return r;
  endfunction

  // Result side: checks every accepted beat and idles in random bursts. A long hold
  // asked for by the sender keeps out_ready low so that the block backs up.
  int stall_left = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (awaited_beats.size() == 0) begin
        $display("%0t: unexpected result beat kind=%0d addr=%h rdata=%h beat=%0d last=%0b",
                 $time, out_kind, out_bus_addr, out_rdata, out_beat, out_last);
        n_errors++;
      end else begin
        resp_t e;
        e = awaited_beats.pop_front();
        if (out_kind !== e.kind || out_bus_addr !== e.bus_addr || out_rdata !== e.rdata ||
            out_beat !== e.beat || out_last !== e.last) begin
          $display("%0t: mismatch expected kind=%0d addr=%h rdata=%h beat=%0d last=%0b",
                   $time, e.kind, e.bus_addr, e.rdata, e.beat, e.last);
          $display("%0t:          actual   kind=%0d addr=%h rdata=%h beat=%0d last=%0b",
                   $time, out_kind, out_bus_addr, out_rdata, out_beat, out_last);
          n_errors++;
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_long) begin
      hold_long = 1'b0;
      hold_left = LONG_HOLD;
      out_ready <= 1'b0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: counts cycles with no beat moving on either side. The limit covers a
  // full clearing sweep plus the long receiver hold several times over.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= DOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, DOG_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  row_t plan[$];

  initial begin
    req_t rq;
    sh_wbe = 1'b1;
    miss_open = 1'b0;
    fills_seen = '0;
    for (int i = 0; i < NSLOT; i++) begin
      sh_valid[i] = 1'b0;
      sh_dirty[i] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: misalignment, stray fill, busy rejection, fill-completed misses,
    // a dirty conflict eviction and every maintenance op.
    plan.push_back(mk(OP_LOAD, 32'h1, 2'd1, '0, 1, K_REJECT));
    plan.push_back(mk(OP_FILL, 32'h0, 2'd0, '1, 1, K_REJECT));
    plan.push_back(mk(OP_WB_IDX, 32'h0, 2'd0, '0, 1, K_MAINT));
    plan.push_back(mk(OP_LOAD, 32'h0, 2'd3, '0, 0, K_LOAD));
    plan.push_back(mk(OP_STORE, 32'h0, 2'd0, '0, 1, K_REJECT));
    plan.push_back(mk(OP_FILL, 32'hFFFFFFFF, 2'd3, '1, 0, K_LOAD));
    plan.push_back(mk(OP_FILL, 32'h0, 2'd0, '0, 0, K_LOAD));
    plan.push_back(mk(OP_FILL, 32'h0, 2'd0, 64'h0123456789ABCDEF, 0, K_LOAD));
    plan.push_back(mk(OP_FILL, 32'h0, 2'd0, 64'h8000000000000001, 0, K_LOAD));
    plan.push_back(mk(OP_STORE, 32'h4, 2'd2, 64'hFFFFFFFFDEADBEEF, 0, K_STORE));
    plan.push_back(mk(OP_LOAD, 32'h7, 2'd0, '0, 0, K_LOAD));
    plan.push_back(mk(OP_STORE, 32'hFFFFFFF8, 2'd3, '1, 0, K_STORE));
    for (int i = 0; i < 4; i++) plan.push_back(mk(OP_FILL, 32'h0, 2'd0, {2{$urandom}}, 0,
                                                   K_LOAD));
    plan.push_back(mk(OP_LOAD, 32'h8000, 2'd1, '0, 0, K_LOAD));
    for (int i = 0; i < 4; i++) plan.push_back(mk(OP_FILL, 32'h0, 2'd0, {2{$urandom}}, 0,
                                                   K_LOAD));
    plan.push_back(mk(OP_WB_LINE, 32'hFFFFFFE0, 2'd0, '0, 0, K_MAINT));
    plan.push_back(mk(OP_WB_INV, 32'hFFFFFFF0, 2'd0, '0, 0, K_MAINT));
    plan.push_back(mk(OP_INV, 32'h8000, 2'd0, '0, 0, K_MAINT));
    plan.push_back(mk(OP_INV_ALL, 32'h0, 2'd0, '0, 1, K_MAINT));

    foreach (plan[i]) begin
      offer(plan[i].rq, plan[i].typed, plan[i].tkind);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      // Phase changes of the write-back register happen only with the block idle.
      if (k == 100 || k == 200 || k == 300) begin
        drain_sender();
        while (miss_open) begin
          rq = pick_req();
          rq.op = OP_FILL;
          offer(rq, 0, K_LOAD);
        end
        drain_sender();
        set_write_back(k != 200 ? 1'b0 : 1'b1);
      end
      if (k == 150) hold_long = 1'b1;
      if (k == 340) quiet = 1'b1;
      rq = pick_req();
      offer(rq, 0, K_LOAD);
      if (k == 250) begin
        drain_sender();
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end
    end
    drain_sender();
    repeat (50) @(posedge clk);

    $display("tb: %0d requests, %0d result beats, %0d hits, %0d write-back beats,",
             n_items, n_results, n_hits, n_wbeats);
    $display("tb: write-back toggled off and on, long output hold and sender drain done");
    if (n_errors == 0 && awaited_beats.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/dmwc_pkg.sv
rtl/dmwc_ram.sv
rtl/direct_mapped_writeback_cache_core.sv
tb/sv/tb.sv
